@@ rtl/page_free_list_allocator_unit_macros.svh @@
// Assertion macros used by the page free-list allocator sequencer.
`ifndef PAGE_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define PAGE_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define PFLA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define PFLA_IMPLY(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);
`else
`define PFLA_ASSERT(lbl, prop, msg)
`define PFLA_IMPLY(lbl, cond, prop, msg)
`endif

`endif

@@ rtl/pfla_pkg.sv @@
// Shared types and constants of the page free-list allocator.
package pfla_pkg;

    localparam int MAX_PAGES_DEF = 1024;
    localparam int PAGE_W        = 10;
    localparam int STAT_W        = 2;
    localparam int TDATA_W       = 16;

    localparam logic [0:0] OP_ALLOC = 1'b0;
    localparam logic [0:0] OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    // result handed from the sequencer to the output stage
    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
        logic [STAT_W-1:0] status;
    } pfla_res_t;

endpackage

@@ rtl/page_free_list_allocator_unit.sv @@
// Top level of the LIFO page free-list allocator with its output register.
// From accept to result beat: a free or an error goes straight to the done state; an
// alloc from a non-empty list reads the link memory and pops; an alloc that grows the
// page store first writes one link per new page, then reads and pops. One item in flight:
// the next is taken once the result is in the output register.
// Reset (aresetn low, synchronous): list empty, page count 1, no result pending;
// link memory keeps its contents and needs no clearing pass.
module page_free_list_allocator_unit import pfla_pkg::*; #(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [9:0] page_in, rest zero
    input  logic [0:0]         s_tuser,   // [0] op
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [9:0] page_out, rest zero
    output logic [STAT_W-1:0]  m_tuser    // [1:0] status
);

    pfla_res_t         res;
    logic              res_take;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [PAGE_W-1:0] page_out_reg;
    logic [STAT_W-1:0] status_reg;

    // sequencer: link memory, head, page count, growth loop
    pfla_ctrl #(.MAX_PAGES(MAX_PAGES)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_page  (s_tdata[PAGE_W-1:0]),
        .res      (res),
        .res_take (res_take)
    );

    // output register loads when empty or drained in the same cycle
    assign res_take      = res.valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid_next = res_take || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (res_take) begin
            page_out_reg <= res.page;
            status_reg   <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(page_out_reg);
    assign m_tuser  = status_reg;

endmodule

@@ rtl/pfla_alu.sv @@
// Shared adder and limit compare used by the allocator sequencer.
module pfla_alu import pfla_pkg::*; #(
    parameter int W = 12
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] lim,
    output logic [W-1:0] sum,
    output logic         hit
);

    assign sum = a + b;
    assign hit = (sum >= lim);

endmodule

@@ rtl/pfla_ctrl.sv @@
// Sequencer, link memory and list registers of the page free-list allocator.
`include "page_free_list_allocator_unit_macros.svh"
module pfla_ctrl import pfla_pkg::*; #(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [0:0]        in_op,
    input  logic [PAGE_W-1:0] in_page,
    output pfla_res_t         res,
    input  logic              res_take
);

    localparam int PW    = (MAX_PAGES > 2) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W = $clog2(MAX_PAGES + 1);
    localparam int CMP_W = (CNT_W > PAGE_W) ? CNT_W : PAGE_W;
    localparam int AW    = CNT_W + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GROW = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [PW-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]  target_reg, target_next;
    logic [PW-1:0]     res_page_reg, res_page_next;
    logic [STAT_W-1:0] res_stat_reg, res_stat_next;

    logic [PW-1:0] link_mem [MAX_PAGES];
    logic [PW-1:0] rd_data_reg;
    logic          wr_en, rd_en;
    logic [PW-1:0] wr_addr, wr_data, rd_addr;

    logic [AW-1:0] alu_a, alu_b, alu_lim, alu_sum;
    logic          alu_hit;

    logic accept, free_ok;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAGES);

    pfla_alu #(.W(AW)) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .lim (alu_lim),
        .sum (alu_sum),
        .hit (alu_hit)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign free_ok  = (in_page != '0) && (CMP_W'(in_page) < CMP_W'(count_reg));

    // link memory: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            link_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= link_mem[rd_addr];
        end
    end

    always_comb begin
        // idle: count + count against the cap; grow: cur + 1 against target
        if (state_reg == S_GROW) begin
            alu_a   = AW'(cur_reg);
            alu_b   = AW'(1);
            alu_lim = AW'(target_reg);
        end else begin
            alu_a   = AW'(count_reg);
            alu_b   = AW'(count_reg);
            alu_lim = AW'(MAX_CNT);
        end
    end

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        target_next   = target_reg;
        res_page_next = res_page_reg;
        res_stat_next = res_stat_reg;
        wr_en         = 1'b0;
        wr_addr       = PW'(cur_reg);
        wr_data       = head_reg;
        rd_en         = 1'b0;
        rd_addr       = head_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_page_next = '0;
                    res_stat_next = ST_OK;
                    state_next    = S_DONE;
                    if (in_op == OP_FREE) begin
                        if (free_ok) begin
                            wr_en     = 1'b1;
                            wr_addr   = PW'(in_page);
                            head_next = PW'(in_page);
                        end else begin
                            res_stat_next = ST_BAD;
                        end
                    end else if (head_reg != '0) begin
                        rd_en      = 1'b1;
                        state_next = S_POP;
                    end else if (count_reg == MAX_CNT) begin
                        res_stat_next = ST_FULL;
                    end else begin
                        cur_next    = count_reg;
                        target_next = alu_hit ? MAX_CNT : CNT_W'(alu_sum);
                        state_next  = S_GROW;
                    end
                end
            end
            S_GROW: begin
                wr_en     = 1'b1;
                head_next = PW'(cur_reg);
                cur_next  = CNT_W'(alu_sum);
                if (alu_hit) begin
                    count_next = target_reg;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                rd_en      = 1'b1;
                state_next = S_POP;
            end
            S_POP: begin
                res_page_next = head_reg;
                head_next     = rd_data_reg;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= CNT_W'(1);
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        target_reg   <= target_next;
        res_page_reg <= res_page_next;
        res_stat_reg <= res_stat_next;
    end

    assign res.valid  = (state_reg == S_DONE);
    assign res.page   = PAGE_W'(res_page_reg);
    assign res.status = res_stat_reg;

    `PFLA_ASSERT(a_count_cap, (count_reg <= MAX_CNT) && (count_reg != '0),
        "page count out of range")
    `PFLA_IMPLY(a_head_below_count, state_reg == S_IDLE,
        CNT_W'(head_reg) < count_reg, "list head not below page count")
    `PFLA_IMPLY(a_grow_bounds, state_reg == S_GROW,
        (cur_reg < target_reg) && (cur_reg >= count_reg) && (head_reg == '0 ||
        CNT_W'(head_reg) < cur_reg), "growth pointer out of bounds")
    `PFLA_IMPLY(a_ok_alloc_nonzero, (state_reg == S_POP),
        head_reg != '0, "pop from empty list")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the LIFO page free-list allocator stream unit.
module testbench;
    import pfla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one result beat, as the predictor sees it
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [STAT_W-1:0] status;
    } page_result_t;

    // directed stimulus row; want is only used when typed is set
    typedef struct {
        logic              op;
        logic [PAGE_W-1:0] page;
        bit                typed;
        page_result_t      want;
    } stim_row_t;

    localparam int NUM_DIRECTED = 20;
    localparam int NUM_RANDOM   = 430;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;    // [9:0] page_in, rest zero
    logic [0:0]         s_tuser;    // [0] op
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;    // [9:0] page_out, rest zero
    logic [STAT_W-1:0]  m_tuser;    // [1:0] status

    // predictor state: link store, head of free list, page count
    logic [PAGE_W-1:0]  link_mem [MAX_PAGES_DEF];
    logic [PAGE_W-1:0]  free_head;
    int unsigned        page_total;

    page_result_t       pending_results [$];   // oldest expected beat at the front
    logic [PAGE_W-1:0]  held_pages [$];        // pages handed out and not yet freed
    page_result_t       oldest;
    stim_row_t          dir_rows [NUM_DIRECTED];

    int                 mismatches = 0;
    int                 beats_sent;
    bit                 s_steady;            // sender burst without gaps
    bit                 hold_done = 1'b0;    // long receiver hold-off already done

    page_free_list_allocator_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // hard stop, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Allocator behavior: push on free, pop on alloc, double the page count
    // when an alloc finds the list empty (new pages pushed low to high, capped at MAX_PAGES_DEF).
    function automatic page_result_t predict_page_op(input logic op,
                                                     input logic [PAGE_W-1:0] pg);
        page_result_t r;
        int unsigned  target;
        r.page   = '0;
        r.status = ST_OK;
        if (op == OP_ALLOC) begin
            if (free_head == '0) begin
                if (page_total >= MAX_PAGES_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    target = page_total * 2;
                    if (target > MAX_PAGES_DEF)
                        target = MAX_PAGES_DEF;
                    for (int unsigned p = page_total; p < target; p++) begin
                        link_mem[p] = free_head;
                        free_head   = p[PAGE_W-1:0];
                    end
                    page_total = target;
                end
            end
            if (r.status == ST_OK && free_head != '0) begin
                r.page    = free_head;
                free_head = link_mem[free_head];
            end
        end else if (pg == '0 || pg >= page_total) begin
            r.status = ST_BAD;
        end else begin
            link_mem[pg] = free_head;
            free_head    = pg;
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones, none in a steady burst
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic note_mismatch(input string what, input page_result_t want,
                                 input logic [TDATA_W-1:0] d, input logic [STAT_W-1:0] u);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch (%s): expected page %0d status %0d, got tdata 0x%h tuser %0d",
                     $realtime, what, want.page, want.status, d, u);
    endtask

    // Offer one beat, wait for the handshake, then predict its result.
    task automatic send_beat(input logic op, input logic [PAGE_W-1:0] pg, input bit typed,
                             input page_result_t want, output page_result_t got);
        int gap;
        int idx [$];
        if (beats_sent % 40 == 0)
            s_steady = ($urandom_range(0, 3) == 0);
        gap = pick_gap(s_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W-PAGE_W){1'b0}}, pg};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        got = predict_page_op(op, pg);
        pending_results.push_back(typed ? want : got);
        // track pages the unit handed us so later frees are well formed
        if (op == OP_ALLOC && got.status == ST_OK) begin
            held_pages.push_back(got.page);
        end else if (op == OP_FREE && got.status == ST_OK) begin
            idx = held_pages.find_first_index(x) with (x == pg);
            if (idx.size() > 0)
                held_pages.delete(idx[0]);
        end
    endtask

    // result side: every accepted beat is checked against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("beat with nothing expected", '0, m_tdata, m_tuser);
            end else begin
                oldest = pending_results.pop_front();
                if (m_tdata !== {{(TDATA_W-PAGE_W){1'b0}}, oldest.page})
                    note_mismatch("page_out", oldest, m_tdata, m_tuser);
                if (m_tuser !== oldest.status)
                    note_mismatch("status", oldest, m_tdata, m_tuser);
            end
        end
    end

    // Receiver: random ready with gaps, plus one long hold-off once the
    // sender is well into the random part so the unit backs up.
    initial begin : ready_driver
        int n;
        int gap;
        bit steady;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!hold_done && beats_sent >= 60) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                steady = ($urandom_range(0, 4) == 0);
                n = steady ? $urandom_range(20, 60) : $urandom_range(1, 8);
                m_tready <= 1'b1;
                repeat (n) @(posedge aclk);
                gap = pick_gap(steady);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        page_result_t      res;
        page_result_t      none;
        logic              op;
        logic [PAGE_W-1:0] pg;
        int                r;

        none       = '0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_ALLOC;
        beats_sent = 0;
        s_steady   = 1'b0;
        free_head  = '0;
        page_total = 1;

        // Directed part. Error codes and free results are typed in; allocs
        // (growth order, LIFO reuse, repeated hand-out) come from the predictor.
        // The double free is the last free, followed only by allocs: it leaves a loop in the list for good.
        dir_rows = '{
            '{OP_FREE,  10'd0,    1'b1, '{10'd0, ST_BAD}},  // header page
            '{OP_FREE,  10'd1,    1'b1, '{10'd0, ST_BAD}},  // only header exists
            '{OP_FREE,  10'd1023, 1'b1, '{10'd0, ST_BAD}},  // top page number
            '{OP_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},   // first growth 1 -> 2
            '{OP_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},   // growth 2 -> 4, highest first
            '{OP_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},
            '{OP_FREE,  10'd4,    1'b1, '{10'd0, ST_BAD}},  // equal to page count
            '{OP_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},   // growth 4 -> 8
            '{OP_FREE,  10'd7,    1'b1, '{10'd0, ST_OK}},
            '{OP_FREE,  10'd8,    1'b1, '{10'd0, ST_BAD}},  // equal to page count
            '{OP_FREE,  10'd682,  1'b1, '{10'd0, ST_BAD}},  // alternating bits
            '{OP_FREE,  10'd341,  1'b1, '{10'd0, ST_BAD}},
            '{OP_FREE,  10'd1,    1'b1, '{10'd0, ST_OK}},
            '{OP_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},
            '{OP_ALLOC, 10'd1023, 1'b0, '{10'd0, ST_OK}},   // page_in ignored on alloc
            '{OP_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},
            '{OP_FREE,  10'd3,    1'b1, '{10'd0, ST_OK}},
            '{OP_FREE,  10'd3,    1'b1, '{10'd0, ST_OK}},   // double free, not caught
            '{OP_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},
            '{OP_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}}    // same page handed out again
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].op, dir_rows[i].page, dir_rows[i].typed,
                      dir_rows[i].want, res);

        // Random part: mostly allocs and frees of pages we hold, plus
        // double frees, header or out-of-range frees and raw noise.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            r  = $urandom_range(0, 99);
            op = OP_ALLOC;
            pg = PAGE_W'($urandom_range(0, 1023));
            if (r >= 50 && r < 80 && held_pages.size() > 0) begin
                op = OP_FREE;
                pg = held_pages[$urandom_range(0, held_pages.size() - 1)];
            end else if (r >= 80 && r < 87) begin
                op = OP_FREE;
                pg = PAGE_W'($urandom_range(1, page_total - 1));
            end else if (r >= 87 && r < 93) begin
                op = OP_FREE;
                if ($urandom_range(0, 1) == 0 || page_total > 1023)
                    pg = '0;
                else
                    pg = PAGE_W'($urandom_range(page_total, 1023));
            end else if (r >= 93) begin
                op = OP_FREE;
            end
            send_beat(op, pg, 1'b0, none, res);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
